/* rtl/core/paac_pkg.sv */
`timescale 1ns / 1ps
package paac_pkg;

    localparam int MAX_SEQUENCE = 1024;
    localparam int SEQ_AW       = $clog2(MAX_SEQUENCE);
    localparam int LEN_W        = SEQ_AW + 1;
    localparam int ALPHABET     = 24;
    localparam int SYM_W        = 5;
    localparam int MAX_PROPS    = 4;
    localparam int PROP_W       = 2;
    localparam int PC_W         = 3;
    localparam int MAX_LAG      = 10;
    localparam int LAG_W        = 4;
    localparam int SC_W         = 5;
    localparam int TAB_DEPTH    = MAX_PROPS * ALPHABET * ALPHABET;
    localparam int TAB_AW       = $clog2(TAB_DEPTH);
    localparam int MAX_FEAT     = 64;
    localparam int FEAT_W       = 6;
    localparam int CNT_W        = LEN_W;
    localparam int VAL_W        = 16;
    localparam int RAW_W        = 34;
    localparam int SUM_W        = 40;
    localparam int ACC_W        = 28;
    localparam int PROD_W       = 45;
    localparam int DVD_W        = 57;
    localparam int DVS_W        = 40;
    localparam int DIV_CW       = 6;
    localparam int SPAN_W       = LEN_W + 2;
    localparam int PERCENT      = 100;
    localparam int COMP_SHIFT   = 24;
    localparam int NORM_SHIFT   = 16;
    localparam int OUT_W        = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROPS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYMS   = 3'd4;

    localparam logic [1:0] MODE_PER_PROP = 2'd2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_RESIDUE = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [1:0]              table_select;
        logic [4:0]              table_row;
        logic [4:0]              table_col;
        logic signed [VAL_W-1:0] table_value;
        logic [4:0]              residue;
        logic                    sequence_end;
    } in_item_t;

    typedef struct packed {
        logic [FEAT_W-1:0]       feature_index;
        logic signed [OUT_W-1:0] feature_value;
        logic                    error;
        logic                    final_res;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_ERR,
        S_COMP,
        S_COMP_W,
        S_LAG_INIT,
        S_SEQ,
        S_SEQB,
        S_TAB,
        S_TAB_W,
        S_MUL,
        S_LDIV,
        S_LDIV_W,
        S_NORM_RD,
        S_NORM,
        S_NORM_W,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic              busy;
        logic              cnt_clear;
        logic              s_clear;
        logic              comp_start;
        logic              lag_clear;
        logic              seq_first;
        logic              seq_cap;
        logic              acc_en;
        logic              mul_en;
        logic              lag_start;
        logic              raw_we;
        logic              norm_start;
        logic              emit;
        logic              emit_zero;
        logic              emit_err;
        logic              final_res;
        logic [FEAT_W-1:0] feat;
        logic [LEN_W-1:0]  j;
        logic [LAG_W-1:0]  m;
        logic [PROP_W-1:0] k;
        logic [PROP_W-1:0] kf;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LAG_W-1:0] lag;
        logic [PC_W-1:0]  pc;
        logic [SC_W-1:0]  sc;
        logic             mode2;
        logic             div_done;
        logic             s_zero;
    } dp_status_t;

endpackage

/* rtl/core/paac_ram.sv */
`timescale 1ns / 1ps
module paac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/paac_div.sv */
`timescale 1ns / 1ps
module paac_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [paac_pkg::DVD_W-1:0] dividend,
    input  logic [paac_pkg::DVS_W-1:0] divisor,
    output logic [paac_pkg::DVD_W-1:0] quotient,
    output logic                       done
);
    import paac_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W:0]    shifted;
    logic [DVS_W:0]    diff;

    // one restoring step per cycle, msb first
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DVD_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DVS_W])
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* rtl/core/paac_ctrl.sv */
`timescale 1ns / 1ps
module paac_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  paac_pkg::in_item_t     in_item,
    input  paac_pkg::dp_status_t   sts,
    output paac_pkg::ctrl_cmd_t    cmd
);
    import paac_pkg::*;

    ctrl_state_t       state_reg, state_next;
    logic [FEAT_W-1:0] feat_reg, feat_next;
    logic [FEAT_W-1:0] last_reg, last_next;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic [LAG_W-1:0]  m_reg, m_next;
    logic [PROP_W-1:0] k_reg, k_next;
    logic [PROP_W-1:0] kf_reg, kf_next;
    logic              seq_end_go;
    logic [LEN_W-1:0]  span;
    logic              k_more;
    logic              kf_more;

    assign seq_end_go = start && (state_reg == S_IDLE) && (in_item.command == CMD_RESIDUE)
                        && in_item.sequence_end;
    assign span    = sts.len - LEN_W'(m_reg);
    assign k_more  = (PC_W'(k_reg) + 1'b1) < sts.pc;
    assign kf_more = sts.mode2 && ((PC_W'(kf_reg) + 1'b1) < sts.pc);

    always_comb
    begin
        state_next = state_reg;
        feat_next  = feat_reg;
        last_next  = last_reg;
        j_next     = j_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        kf_next    = kf_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (seq_end_go)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                feat_next = '0;
                if (sts.len <= LEN_W'(sts.lag))
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    state_next = S_COMP;
                end
            end
            S_ERR:      state_next = S_IDLE;
            S_COMP:     state_next = S_COMP_W;
            S_COMP_W:
            begin
                if (sts.div_done)
                begin
                    if (feat_reg == FEAT_W'(sts.sc - 1'b1))
                    begin
                        if (sts.lag == '0)
                        begin
                            last_next  = feat_reg;
                            feat_next  = '0;
                            state_next = S_NORM_RD;
                        end
                        else
                        begin
                            m_next     = LAG_W'(1);
                            feat_next  = feat_reg + 1'b1;
                            state_next = S_LAG_INIT;
                        end
                    end
                    else
                    begin
                        feat_next  = feat_reg + 1'b1;
                        state_next = S_COMP;
                    end
                end
            end
            S_LAG_INIT:
            begin
                j_next     = '0;
                k_next     = '0;
                state_next = S_SEQ;
            end
            S_SEQ:      state_next = S_SEQB;
            S_SEQB:     state_next = S_TAB;
            S_TAB:      state_next = S_TAB_W;
            S_TAB_W:
            begin
                if (k_more)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_TAB;
                end
                else
                begin
                    k_next = '0;
                    if ((j_reg + 1'b1) < span)
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_SEQ;
                    end
                    else
                    begin
                        kf_next    = '0;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:      state_next = S_LDIV;
            S_LDIV:     state_next = S_LDIV_W;
            S_LDIV_W:
            begin
                if (sts.div_done)
                begin
                    if (kf_more)
                    begin
                        kf_next    = kf_reg + 1'b1;
                        feat_next  = feat_reg + 1'b1;
                        state_next = S_MUL;
                    end
                    else if (m_reg == sts.lag)
                    begin
                        last_next  = feat_reg;
                        feat_next  = '0;
                        state_next = S_NORM_RD;
                    end
                    else
                    begin
                        m_next     = m_reg + 1'b1;
                        feat_next  = feat_reg + 1'b1;
                        state_next = S_LAG_INIT;
                    end
                end
            end
            S_NORM_RD:  state_next = S_NORM;
            S_NORM, S_NORM_W:
            begin
                if ((state_reg == S_NORM && sts.s_zero) || (state_reg == S_NORM_W && sts.div_done))
                begin
                    if (feat_reg == last_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        feat_next  = feat_reg + 1'b1;
                        state_next = S_NORM_RD;
                    end
                end
                else if (state_reg == S_NORM)
                begin
                    state_next = S_NORM_W;
                end
            end
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.busy      = (state_reg != S_IDLE);
        cmd.feat      = feat_reg;
        cmd.j         = j_reg;
        cmd.m         = m_reg;
        cmd.k         = k_reg;
        cmd.kf        = kf_reg;
        cmd.final_res = (feat_reg == last_reg);
        unique case (state_reg)
            S_CHECK:    cmd.s_clear = 1'b1;
            S_ERR:
            begin
                cmd.emit_err  = 1'b1;
                cmd.cnt_clear = 1'b1;
            end
            S_COMP:     cmd.comp_start = 1'b1;
            S_COMP_W:   cmd.raw_we     = sts.div_done;
            S_LAG_INIT: cmd.lag_clear  = 1'b1;
            S_SEQ:      cmd.seq_first  = 1'b1;
            S_SEQB:     cmd.seq_cap    = 1'b1;
            S_TAB_W:    cmd.acc_en     = 1'b1;
            S_MUL:      cmd.mul_en     = 1'b1;
            S_LDIV:     cmd.lag_start  = 1'b1;
            S_LDIV_W:   cmd.raw_we     = sts.div_done;
            S_NORM:
            begin
                cmd.emit       = sts.s_zero;
                cmd.emit_zero  = sts.s_zero;
                cmd.norm_start = !sts.s_zero;
            end
            S_NORM_W:   cmd.emit      = sts.div_done;
            S_DONE:     cmd.cnt_clear = 1'b1;
            default:    cmd.busy      = (state_reg != S_IDLE);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            feat_reg  <= '0;
            last_reg  <= '0;
            j_reg     <= '0;
            m_reg     <= '0;
            k_reg     <= '0;
            kf_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            feat_reg  <= feat_next;
            last_reg  <= last_next;
            j_reg     <= j_next;
            m_reg     <= m_next;
            k_reg     <= k_next;
            kf_reg    <= kf_next;
        end
    end

`ifndef SYNTHESIS
    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(cmd.emit || cmd.emit_err))
        else $error("result strobe while idle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_COMP_W || state_reg == S_LDIV_W
                          || state_reg == S_NORM_W))
        else $error("divider finished outside a wait state");

    a_err_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERR) |=> (state_reg == S_IDLE))
        else $error("error beat not followed by idle");

    a_prop_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAB_W) |-> (PC_W'(k_reg) < sts.pc))
        else $error("property index beyond count");
`endif

endmodule

/* rtl/core/paac_dp.sv */
`timescale 1ns / 1ps
module paac_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  paac_pkg::in_item_t              in_item,
    input  logic                            cfg_valid,
    input  logic [paac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [paac_pkg::CFG_DATA_W-1:0] cfg_data,
    input  paac_pkg::ctrl_cmd_t             cmd,
    output paac_pkg::dp_status_t            sts,
    output logic                            result_valid,
    output paac_pkg::out_item_t             result
);
    import paac_pkg::*;

    logic [1:0]         mode_reg;
    logic [LAG_W-1:0]   lag_reg;
    logic [15:0]        weight_reg;
    logic [PC_W-1:0]    props_reg;
    logic [SC_W-1:0]    syms_reg;
    logic [LAG_W-1:0]   lag_eff;
    logic [PC_W-1:0]    pc_eff;
    logic [SC_W-1:0]    sc_eff;
    logic               mode2;

    logic               accept;
    logic               res_go;
    logic [LEN_W-1:0]   len_reg;
    logic [CNT_W-1:0]   counts_reg [ALPHABET];
    logic [SYM_W-1:0]   cnt_idx;
    logic [CNT_W-1:0]   cnt_rd;

    logic               tab_we;
    logic [TAB_AW-1:0]  tab_waddr;
    logic [TAB_AW-1:0]  tab_raddr;
    logic [VAL_W-1:0]   tab_rdata;
    logic               tab_ok_reg;

    logic               seq_we;
    logic [SEQ_AW-1:0]  seq_raddr;
    logic [SYM_W-1:0]   seq_rdata;
    logic [SYM_W-1:0]   a_reg;

    logic signed [ACC_W-1:0]  acc_reg [MAX_PROPS];
    logic [PROP_W-1:0]        acc_sel;
    logic signed [ACC_W-1:0]  acc_rd;
    logic signed [16:0]       weight_s;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0]        prod_mag;
    logic [SPAN_W-1:0]        span;
    logic [SPAN_W-1:0]        lag_div;

    logic signed [RAW_W-1:0]  raw_wdata;
    logic signed [RAW_W-1:0]  raw_rdata;
    logic [RAW_W-1:0]         raw_mag;
    logic signed [SUM_W-1:0]  s_reg;
    logic [SUM_W-1:0]         s_mag;

    logic               div_start;
    logic [DVD_W-1:0]   dvd;
    logic [DVS_W-1:0]   dvs;
    logic [DVD_W-1:0]   quo;
    logic               div_done;
    logic               neg_reg;
    logic [OUT_W-1:0]   sat_val;

    // register file, out-of-range values folded to the nearest legal one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 2'd1;
            lag_reg    <= LAG_W'(1);
            weight_reg <= 16'd205;
            props_reg  <= PC_W'(1);
            syms_reg   <= SC_W'(20);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                REG_LAG:    lag_reg    <= cfg_data[LAG_W-1:0];
                REG_WEIGHT: weight_reg <= cfg_data;
                REG_PROPS:  props_reg  <= cfg_data[PC_W-1:0];
                REG_SYMS:   syms_reg   <= cfg_data[SC_W-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    assign mode2   = (mode_reg == MODE_PER_PROP);
    assign lag_eff = (lag_reg > LAG_W'(MAX_LAG)) ? LAG_W'(MAX_LAG) : lag_reg;
    assign pc_eff  = (props_reg == '0) ? PC_W'(1)
                   : ((props_reg > PC_W'(MAX_PROPS)) ? PC_W'(MAX_PROPS) : props_reg);
    assign sc_eff  = (syms_reg < SC_W'(2)) ? SC_W'(2)
                   : ((syms_reg > SC_W'(ALPHABET)) ? SC_W'(ALPHABET) : syms_reg);

    // input beats
    assign accept = start && !cmd.busy;
    assign res_go = accept && (in_item.command == CMD_RESIDUE)
                    && (len_reg < LEN_W'(MAX_SEQUENCE));
    assign seq_we = res_go;
    assign tab_we = accept && (in_item.command == CMD_LOAD)
                    && (32'(in_item.table_select) < MAX_PROPS)
                    && (in_item.table_row < SYM_W'(ALPHABET))
                    && (in_item.table_col < SYM_W'(ALPHABET));
    assign tab_waddr = (TAB_AW'(in_item.table_select) * TAB_AW'(ALPHABET)
                        + TAB_AW'(in_item.table_row)) * TAB_AW'(ALPHABET)
                       + TAB_AW'(in_item.table_col);

    assign cnt_idx = cmd.busy ? cmd.feat[SYM_W-1:0] : in_item.residue;
    assign cnt_rd  = (cnt_idx < SYM_W'(ALPHABET)) ? counts_reg[cnt_idx] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            for (int i = 0; i < ALPHABET; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (cmd.cnt_clear)
        begin
            len_reg <= '0;
            for (int i = 0; i < ALPHABET; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (res_go)
        begin
            len_reg <= len_reg + 1'b1;
            if (in_item.residue < SYM_W'(ALPHABET))
            begin
                counts_reg[cnt_idx] <= cnt_rd + 1'b1;
            end
        end
    end

    paac_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SEQUENCE)) u_seq (
        .clk   (clk),
        .we    (seq_we),
        .waddr (len_reg[SEQ_AW-1:0]),
        .wdata (in_item.residue),
        .raddr (seq_raddr),
        .rdata (seq_rdata)
    );

    // first symbol of the pair at j, second at j + lag
    assign seq_raddr = cmd.seq_first ? cmd.j[SEQ_AW-1:0]
                                     : SEQ_AW'(cmd.j + LEN_W'(cmd.m));

    assign tab_raddr = (TAB_AW'(cmd.k) * TAB_AW'(ALPHABET) + TAB_AW'(a_reg))
                       * TAB_AW'(ALPHABET) + TAB_AW'(seq_rdata);

    paac_ram #(.WIDTH(VAL_W), .DEPTH(TAB_DEPTH)) u_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (in_item.table_value),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.seq_cap)
        begin
            a_reg <= seq_rdata;
        end
        // large symbols contribute zero
        tab_ok_reg <= (a_reg < SYM_W'(ALPHABET)) && (seq_rdata < SYM_W'(ALPHABET));
    end

    assign acc_sel  = cmd.mul_en ? cmd.kf : (mode2 ? cmd.k : '0);
    assign acc_rd   = acc_reg[acc_sel];
    assign weight_s = {1'b0, weight_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.lag_clear)
        begin
            for (int i = 0; i < MAX_PROPS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (cmd.acc_en && tab_ok_reg)
        begin
            acc_reg[acc_sel] <= acc_rd + ACC_W'($signed(tab_rdata));
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(acc_rd) * PROD_W'(weight_s);
        end
    end

    assign span     = SPAN_W'(len_reg - LEN_W'(cmd.m));
    assign lag_div  = mode2 ? span : SPAN_W'(span * SPAN_W'(pc_eff));
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign raw_mag  = raw_rdata[RAW_W-1] ? RAW_W'(-raw_rdata) : RAW_W'(raw_rdata);
    assign s_mag    = s_reg[SUM_W-1] ? SUM_W'(-s_reg) : SUM_W'(s_reg);

    assign div_start = cmd.comp_start || cmd.lag_start || cmd.norm_start;

    always_comb
    begin
        priority if (cmd.comp_start)
        begin
            dvd = DVD_W'({cnt_rd, {COMP_SHIFT{1'b0}}});
            dvs = DVS_W'(len_reg);
        end
        else if (cmd.lag_start)
        begin
            dvd = DVD_W'(prod_mag);
            dvs = DVS_W'(lag_div);
        end
        else
        begin
            dvd = (DVD_W'(raw_mag) * DVD_W'(PERCENT)) << NORM_SHIFT;
            dvs = s_mag;
        end
    end

    paac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .quotient (quo),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.comp_start)
        begin
            neg_reg <= 1'b0;
        end
        else if (cmd.lag_start)
        begin
            neg_reg <= prod_reg[PROD_W-1];
        end
        else if (cmd.norm_start)
        begin
            neg_reg <= raw_rdata[RAW_W-1] ^ s_reg[SUM_W-1];
        end
    end

    assign raw_wdata = neg_reg ? -$signed(quo[RAW_W-1:0]) : $signed(quo[RAW_W-1:0]);

    paac_ram #(.WIDTH(RAW_W), .DEPTH(MAX_FEAT)) u_raw (
        .clk   (clk),
        .we    (cmd.raw_we),
        .waddr (cmd.feat),
        .wdata (raw_wdata),
        .raddr (cmd.feat),
        .rdata (raw_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.s_clear)
        begin
            s_reg <= '0;
        end
        else if (cmd.raw_we)
        begin
            s_reg <= s_reg + SUM_W'(raw_wdata);
        end
    end

    // saturate the quotient to a signed 32-bit feature
    always_comb
    begin
        if (neg_reg)
        begin
            sat_val = (quo > DVD_W'(33'h0_8000_0000)) ? 32'h8000_0000 : OUT_W'(-quo);
        end
        else
        begin
            sat_val = (quo > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.emit || cmd.emit_err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit || cmd.emit_err)
        begin
            result.feature_index <= cmd.emit_err ? '0 : cmd.feat;
            result.feature_value <= (cmd.emit_err || cmd.emit_zero) ? '0 : sat_val;
            result.error         <= cmd.emit_err;
            result.final_res     <= cmd.emit_err ? 1'b1 : cmd.final_res;
        end
    end

    assign sts.len      = len_reg;
    assign sts.lag      = lag_eff;
    assign sts.pc       = pc_eff;
    assign sts.sc       = sc_eff;
    assign sts.mode2    = mode2;
    assign sts.div_done = div_done;
    assign sts.s_zero   = (s_reg == '0);

endmodule

/* rtl/core/pseudo_amino_acid_composition.sv */
`timescale 1ns / 1ps
// pseudo amino acid composition engine
// input: a beat is taken when start is high and busy is low. command 0 writes
//   one property table entry, command 1 appends one residue; loads and
//   residues can stream one per cycle while busy is low.
// the residue with sequence_end raises busy; the block then computes
//   symbol_count composition values and the lag factors, normalizes them to
//   sum to 100 (Q15.16) and emits them on result/result_valid, one beat per strobe.
// divider: every feature goes through one shared shift-subtract divider,
//   once for its raw value and once more for normalization unless the sum
//   is zero; each lag walks all L-m residue pairs, reading the two symbols
//   from sequence memory and then one table entry per property for each pair.
// a sequence no longer than the lag gives one error beat, after the check and
//   error states and the output register. configuration goes through cfg_valid/cfg_ready (always ready).
// reset sets the state and configuration defaults and clears counts and length;
//   the memories and datapath registers are not cleared. the receiver cannot
//   stall: every result strobe is a single-cycle beat that must be taken.
module pseudo_amino_acid_composition (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  paac_pkg::in_item_t              in_item,
    output logic                            result_valid,
    output paac_pkg::out_item_t             result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [paac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [paac_pkg::CFG_DATA_W-1:0] cfg_data
);
    import paac_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    paac_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_item),
        .sts     (sts),
        .cmd     (cmd)
    );

    paac_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .in_item      (in_item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

    assign busy      = cmd.busy;
    assign cfg_ready = 1'b1;

endmodule
